FILE: sv/kmd_pkg.sv
// Shared types and constants for the keypad matrix debounce block.
package kmd_pkg;

  localparam int ROWS_DEF      = 4;
  localparam int COLUMNS_DEF   = 4;
  localparam int TIME_BITS_DEF = 32;

  localparam logic [15:0] DEBOUNCE_RESET = 16'd50;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // Keys that have a level bit and a keymap byte.
  localparam int MAPPED_KEYS = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE    = 2'd0,
    REG_KEYMAP_LOW  = 2'd1,
    REG_KEYMAP_HIGH = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [15:0] key_levels;
  } in_item_t;

  typedef struct packed {
    logic       key_valid;
    logic [3:0] key_number;
    logic [7:0] key_code;
  } out_item_t;

endpackage

FILE: sv/kmd_state_mem.sv
// Per-key state memory with registered read and reset-cleared valid bits.
module kmd_state_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 34
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [DW-1:0] rd_q;
  logic          rd_v;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Entry never written since reset reads as all zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      rd_v <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_v <= vld[rd_addr];
      end
    end
  end

  assign rd_data = rd_v ? rd_q : '0;

endmodule

FILE: sv/keypad_matrix_debounce.sv
// Keypad matrix scanner with per-key debounce: control, settle logic and registers.
//
// One input transfer is one scan pass. Keys are handled one per cycle in key
// index order by reading each key's stable level, last sample and change time
// from a single-port-read state memory, settling it, and writing it back. A
// pass ends at the last key or at the first confirmed press. The block takes
// the next scan only when idle, once its result is in the output register;
// the result waits while that register holds an item that is stalled.
// State reset is immediate through per-entry valid bits; there is no clearing
// pass. Configuration is accepted every cycle.
module keypad_matrix_debounce #(
  parameter int ROWS      = kmd_pkg::ROWS_DEF,
  parameter int COLUMNS   = kmd_pkg::COLUMNS_DEF,
  parameter int TIME_BITS = kmd_pkg::TIME_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  kmd_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output kmd_pkg::out_item_t               out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [kmd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kmd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import kmd_pkg::*;

  localparam int NKEYS = ROWS * COLUMNS;
  localparam int KW    = (NKEYS > 1) ? $clog2(NKEYS) : 1;
  localparam int CW    = $clog2(NKEYS + 1);
  localparam int DW    = TIME_BITS + 2;

  // configuration
  logic [15:0] debounce_ms;
  logic [63:0] keymap_low;
  logic [63:0] keymap_high;

  // control and pass registers
  state_t               state, state_next;
  logic [TIME_BITS-1:0] now_r;
  logic [15:0]          levels_r;
  logic [CW-1:0]        rd_cnt;
  logic                 ev_vld;
  logic [KW-1:0]        ev_key;
  out_item_t            res;

  // memory interface
  logic          rd_issue;
  logic          wr_en;
  logic [DW-1:0] rd_data;
  logic [DW-1:0] wr_data;

  // settle logic
  logic                 old_stable, old_prev;
  logic [TIME_BITS-1:0] old_time;
  logic [6:0]           key7;
  logic                 level;
  logic [TIME_BITS-1:0] new_time;
  logic [TIME_BITS-1:0] elapsed;
  logic [63:0]          now64, db64;
  logic                 settled;
  logic                 new_stable;
  logic                 press;
  logic [127:0]         keymap;
  logic [7:0]           code;

  logic in_xfer;
  logic finish;
  logic out_load;

  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  kmd_state_mem #(
    .DEPTH (NKEYS),
    .AW    (KW),
    .DW    (DW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (ev_key),
    .wr_data (wr_data),
    .rd_en   (rd_issue),
    .rd_addr (rd_cnt[KW-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    {old_stable, old_prev, old_time} = rd_data;
    key7     = {{(7 - KW){1'b0}}, ev_key};
    level    = (key7 < 7'(MAPPED_KEYS)) ? levels_r[key7[3:0]] : 1'b0;
    // a changed sample restarts the key's timer
    new_time = (level != old_prev) ? now_r : old_time;
    elapsed  = now_r - new_time;
    db64     = {48'd0, debounce_ms};
    settled  = (elapsed > db64[TIME_BITS-1:0]) && (level != old_stable);
    new_stable = settled ? level : old_stable;
    press    = settled && level;
    wr_data  = {new_stable, level, new_time};
    keymap   = {keymap_high, keymap_low};
    code     = (key7 < 7'(MAPPED_KEYS)) ? keymap[key7[3:0]*8 +: 8] : 8'd0;
  end

  assign now64 = {32'd0, in_data.now_ms};

  // control outputs
  always_comb begin
    in_stall = 1'b1;
    rd_issue = 1'b0;
    wr_en    = 1'b0;
    finish   = 1'b0;
    out_load = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_SCAN: begin
        rd_issue = (rd_cnt < CW'(NKEYS));
        wr_en    = ev_vld;
        finish   = ev_vld && (press || (ev_key == KW'(NKEYS - 1)));
      end
      ST_DONE: begin
        out_load = !out_valid || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (finish) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      rd_cnt      <= '0;
      ev_vld      <= 1'b0;
      debounce_ms <= DEBOUNCE_RESET;
      keymap_low  <= '0;
      keymap_high <= '0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_DEBOUNCE:    debounce_ms <= cfg_data[15:0];
          REG_KEYMAP_LOW:  keymap_low  <= cfg_data;
          REG_KEYMAP_HIGH: keymap_high <= cfg_data;
          default: ;
        endcase
      end

      if (in_xfer) begin
        rd_cnt <= '0;
        ev_vld <= 1'b0;
      end else if (state == ST_SCAN) begin
        if (rd_issue) rd_cnt <= rd_cnt + CW'(1);
        ev_vld <= rd_issue;
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      now_r    <= now64[TIME_BITS-1:0];
      levels_r <= in_data.key_levels;
    end
    if (state == ST_SCAN) begin
      ev_key <= rd_cnt[KW-1:0];
    end
    if (finish) begin
      if (press) begin
        res.key_valid  <= 1'b1;
        res.key_number <= key7[3:0];
        res.key_code   <= code;
      end else begin
        res <= '0;
      end
    end
    if (out_load) begin
      out_data <= res;
    end
  end

endmodule
